// ===== design/elfe_pkg.sv =====
// elfe_pkg: shared types, codes and command tables of the encoder link frame engine
// no dependencies; imported by every module of the block

package elfe_pkg;

    // input item operations
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RX_BYTE = 1'b1;

    // result kinds
    localparam logic RESULT_TX    = 1'b0;
    localparam logic RESULT_FRAME = 1'b1;

    // request kinds
    localparam logic [3:0] REQ_ID0    = 4'd0;
    localparam logic [3:0] REQ_ID1    = 4'd1;
    localparam logic [3:0] REQ_ID2    = 4'd2;
    localparam logic [3:0] REQ_ID3    = 4'd3;
    localparam logic [3:0] REQ_EEP_WR = 4'd4;
    localparam logic [3:0] REQ_ID7    = 4'd5;
    localparam logic [3:0] REQ_ID8    = 4'd6;
    localparam logic [3:0] REQ_IDC    = 4'd7;
    localparam logic [3:0] REQ_EEP_RD = 4'd8;

    // results a job produces, at most four
    localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
    localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
    localparam logic [1:0] LAST_IDX_THREE = 2'd2;
    localparam logic [1:0] LAST_IDX_FOUR  = 2'd3;

    // stored reply fields
    typedef struct packed {
        logic [7:0]  control_field;
        logic [7:0]  status_field;
        logic [23:0] position_single;
        logic [23:0] position_multi;
        logic [7:0]  encoder_id;
        logic [7:0]  alarm_field;
        logic [7:0]  eeprom_address_out;
        logic [7:0]  eeprom_data_out;
        logic [7:0]  frame_check;
    } fields_t;

    // one queued job: a command frame or a parsed reply frame
    typedef struct packed {
        logic       is_frame;
        logic [3:0] code;
        logic [7:0] adr;
        logic [7:0] dat;
        fields_t    fields;
    } job_t;

    // command byte of each request kind
    function automatic logic [7:0] cmd_byte(input logic [3:0] code);
        logic [7:0] b;
        unique case (code)
            REQ_ID0:    b = 8'h02;
            REQ_ID1:    b = 8'h8A;
            REQ_ID2:    b = 8'h92;
            REQ_ID3:    b = 8'h1A;
            REQ_EEP_WR: b = 8'h32;
            REQ_ID7:    b = 8'hBA;
            REQ_ID8:    b = 8'hC2;
            REQ_IDC:    b = 8'h62;
            REQ_EEP_RD: b = 8'hEA;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    // reply length in bytes of each request kind
    function automatic logic [3:0] reply_len(input logic [3:0] code);
        logic [3:0] n;
        unique case (code)
            REQ_ID2, REQ_EEP_WR, REQ_EEP_RD: n = 4'd4;
            REQ_ID3:                         n = 4'd11;
            default:                         n = 4'd6;
        endcase
        return n;
    endfunction

endpackage

// ===== design/elfe_front.sv =====
// elfe_front: accepts input transactions, tracks the active request, collects and parses replies
// depends on elfe_pkg; feeds jobs into elfe_queue

module elfe_front #(
    parameter int MAX_REPLY_BYTES = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic [3:0]           request_code,
    input  logic [7:0]           eeprom_address_in,
    input  logic [7:0]           eeprom_data_in,
    input  logic [7:0]           rx_byte,
    input  logic                 q_full,
    output logic                 push,
    output elfe_pkg::job_t       push_job
);
    import elfe_pkg::*;

    localparam int CW = $clog2(MAX_REPLY_BYTES + 1);
    localparam int IW = $clog2(MAX_REPLY_BYTES);

    logic [3:0]    active_request_reg, active_request_next;
    logic          request_issued_reg, request_issued_next;
    logic [3:0]    expected_length_reg, expected_length_next;
    logic [CW-1:0] received_count_reg, received_count_next;
    fields_t       parsed_reg, parsed_next;
    logic [7:0]    reply_reg [MAX_REPLY_BYTES];

    logic          accept;
    logic          store_byte;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] exp_ext;
    logic [7:0]    p [MAX_REPLY_BYTES];

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign exp_ext   = CW'(expected_length_reg);
    assign count_inc = received_count_reg + CW'(1);

    // reply bytes seen with the incoming byte merged in at its slot
    always_comb begin
        for (int i = 0; i < MAX_REPLY_BYTES; i++) begin
            p[i] = (CW'(i) == received_count_reg) ? rx_byte : reply_reg[i];
        end
    end

    // next state, parsing and job push
    always_comb begin
        active_request_next  = active_request_reg;
        request_issued_next  = request_issued_reg;
        expected_length_next = expected_length_reg;
        received_count_next  = received_count_reg;
        parsed_next          = parsed_reg;
        store_byte           = 1'b0;
        push                 = 1'b0;
        push_job             = '0;

        if (accept) begin
            if (operation == OP_REQUEST) begin
                if (request_code <= REQ_EEP_RD) begin
                    active_request_next  = request_code;
                    request_issued_next  = 1'b1;
                    expected_length_next = reply_len(request_code);
                    received_count_next  = '0;
                    push                 = 1'b1;
                    push_job.is_frame    = 1'b0;
                    push_job.code        = request_code;
                    push_job.adr         = eeprom_address_in;
                    push_job.dat         = eeprom_data_in;
                end
            end else if (request_issued_reg && (received_count_reg < exp_ext)
                         && (received_count_reg < CW'(MAX_REPLY_BYTES))) begin
                store_byte          = 1'b1;
                received_count_next = count_inc;
                if (count_inc == exp_ext) begin
                    // full reply: parse per kind
                    unique case (active_request_reg)
                        REQ_ID0, REQ_IDC: begin
                            parsed_next.control_field   = p[0];
                            parsed_next.status_field    = p[1];
                            parsed_next.position_single = {p[4], p[3], p[2]};
                            parsed_next.frame_check     = p[5];
                        end
                        REQ_ID1: begin
                            parsed_next.control_field   = p[0];
                            parsed_next.status_field    = p[1];
                            parsed_next.position_multi  = {p[4], p[3], p[2]};
                            parsed_next.frame_check     = p[5];
                        end
                        REQ_ID2: begin
                            parsed_next.control_field   = p[0];
                            parsed_next.status_field    = p[1];
                            parsed_next.encoder_id      = p[2];
                            parsed_next.frame_check     = p[3];
                        end
                        REQ_ID3: begin
                            parsed_next.control_field   = p[0];
                            parsed_next.status_field    = p[1];
                            parsed_next.position_single = {p[4], p[3], p[2]};
                            parsed_next.encoder_id      = p[5];
                            parsed_next.position_multi  = {p[8], p[7], p[6]};
                            parsed_next.alarm_field     = p[9];
                            parsed_next.frame_check     = p[10];
                        end
                        REQ_EEP_RD: begin
                            parsed_next.control_field      = p[0];
                            parsed_next.eeprom_address_out = p[1];
                            parsed_next.eeprom_data_out    = p[2];
                            parsed_next.frame_check        = p[3];
                        end
                        default: begin
                        end
                    endcase
                    // frame out, then the automatic full-status request
                    push                 = 1'b1;
                    push_job.is_frame    = 1'b1;
                    push_job.code        = REQ_ID3;
                    push_job.fields      = parsed_next;
                    active_request_next  = REQ_ID3;
                    request_issued_next  = 1'b1;
                    expected_length_next = reply_len(REQ_ID3);
                    received_count_next  = '0;
                end
            end
        end
    end

    // control and parsed field registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_request_reg  <= '0;
            request_issued_reg  <= 1'b0;
            expected_length_reg <= '0;
            received_count_reg  <= '0;
            parsed_reg          <= '0;
        end else begin
            active_request_reg  <= active_request_next;
            request_issued_reg  <= request_issued_next;
            expected_length_reg <= expected_length_next;
            received_count_reg  <= received_count_next;
            parsed_reg          <= parsed_next;
        end
    end

    // reply byte store
    always_ff @(posedge aclk) begin
        if (store_byte) begin
            reply_reg[received_count_reg[IW-1:0]] <= rx_byte;
        end
    end

endmodule

// ===== design/elfe_queue.sv =====
// elfe_queue: two-entry job queue between front and back
// depends on elfe_pkg

module elfe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  elfe_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output elfe_pkg::job_t  q_job
);
    import elfe_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_job   = mem_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== design/elfe_back.sv =====
// elfe_back: expands queued jobs into result transactions through an output register
// depends on elfe_pkg; pops elfe_queue

module elfe_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  elfe_pkg::job_t     q_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_kind,
    output logic [7:0]         out_tx_byte,
    output logic               out_tx_last,
    output elfe_pkg::fields_t  out_fields
);
    import elfe_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       kind_reg, kind_next;
    logic [7:0] tx_reg, tx_next;
    logic       last_reg, last_next;
    fields_t    fields_reg, fields_next;

    logic       load;
    logic [1:0] last_idx;
    logic [7:0] cmd;

    assign load = q_valid && (!valid_reg || out_ready);
    assign pop  = load && (idx_reg == last_idx);
    assign cmd  = cmd_byte(q_job.code);

    // number of results of the job at the queue head
    always_comb begin
        priority if (q_job.is_frame)           last_idx = LAST_IDX_TWO;
        else if (q_job.code == REQ_EEP_WR)     last_idx = LAST_IDX_FOUR;
        else if (q_job.code == REQ_EEP_RD)     last_idx = LAST_IDX_THREE;
        else                                   last_idx = LAST_IDX_ONE;
    end

    // select the next result of the job
    always_comb begin
        valid_next  = valid_reg;
        idx_next    = idx_reg;
        kind_next   = kind_reg;
        tx_next     = tx_reg;
        last_next   = last_reg;
        fields_next = fields_reg;

        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end

        if (load) begin
            valid_next  = 1'b1;
            idx_next    = (idx_reg == last_idx) ? 2'd0 : idx_reg + 2'd1;
            kind_next   = RESULT_TX;
            last_next   = (idx_reg == last_idx);
            fields_next = '0;
            if (q_job.is_frame) begin
                if (idx_reg == 2'd0) begin
                    kind_next   = RESULT_FRAME;
                    tx_next     = 8'h00;
                    last_next   = 1'b0;
                    fields_next = q_job.fields;
                end else begin
                    tx_next = cmd_byte(REQ_ID3);
                end
            end else begin
                unique case (idx_reg)
                    2'd0: tx_next = cmd;
                    2'd1: tx_next = q_job.adr;
                    2'd2: tx_next = (q_job.code == REQ_EEP_WR) ? q_job.dat
                                                                : cmd ^ q_job.adr;
                    default: tx_next = cmd ^ q_job.adr ^ q_job.dat;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        tx_reg     <= tx_next;
        last_reg   <= last_next;
        fields_reg <= fields_next;
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_tx_byte = tx_reg;
    assign out_tx_last = last_reg;
    assign out_fields  = fields_reg;

endmodule

// ===== design/encoder_link_frame_engine.sv =====
// encoder_link_frame_engine: top level of the encoder link host frame engine
// depends on elfe_pkg, elfe_front, elfe_queue, elfe_back

// Host side of a serial absolute-encoder link. An input transaction either issues
// a request or delivers one received reply byte; the input side takes one
// transaction per cycle whenever the two-entry job queue has room, and updates
// the receive state in that same cycle. A request yields 1 command byte (3 for an
// EEPROM read, 4 for an EEPROM write, with an XOR check byte last); the byte
// that completes a reply yields 2 results: the parsed frame with all stored
// fields, then the automatic full-status command 0x1A. Results leave one per
// cycle from the output register while m_ready is high, so the sustained rate
// is set by the number of results per transaction at the output port; reply
// bytes that complete nothing give no result.
// Bytes that arrive before any request or beyond the expected length are
// dropped, and request codes above 8 are ignored.

module encoder_link_frame_engine #(
    parameter int MAX_REPLY_BYTES = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [3:0]  s_request_code,
    input  logic [7:0]  s_eeprom_address_in,
    input  logic [7:0]  s_eeprom_data_in,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_tx_byte,
    output logic        m_tx_last,
    output logic [7:0]  m_control_field,
    output logic [7:0]  m_status_field,
    output logic [23:0] m_position_single,
    output logic [23:0] m_position_multi,
    output logic [7:0]  m_encoder_id,
    output logic [7:0]  m_alarm_field,
    output logic [7:0]  m_eeprom_address_out,
    output logic [7:0]  m_eeprom_data_out,
    output logic [7:0]  m_frame_check
);
    import elfe_pkg::*;

    logic    push, q_full, pop, q_valid;
    job_t    push_job, q_job;
    fields_t out_fields;

    // input side: handshake, receive state, parsing
    elfe_front #(
        .MAX_REPLY_BYTES(MAX_REPLY_BYTES)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_valid),
        .in_ready          (s_ready),
        .operation         (s_operation),
        .request_code      (s_request_code),
        .eeprom_address_in (s_eeprom_address_in),
        .eeprom_data_in    (s_eeprom_data_in),
        .rx_byte           (s_rx_byte),
        .q_full            (q_full),
        .push              (push),
        .push_job          (push_job)
    );

    // job queue
    elfe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    // output side: result sequencing
    elfe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_job       (q_job),
        .pop         (pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_kind    (m_result_kind),
        .out_tx_byte (m_tx_byte),
        .out_tx_last (m_tx_last),
        .out_fields  (out_fields)
    );

    assign m_control_field      = out_fields.control_field;
    assign m_status_field       = out_fields.status_field;
    assign m_position_single    = out_fields.position_single;
    assign m_position_multi     = out_fields.position_multi;
    assign m_encoder_id         = out_fields.encoder_id;
    assign m_alarm_field        = out_fields.alarm_field;
    assign m_eeprom_address_out = out_fields.eeprom_address_out;
    assign m_eeprom_data_out    = out_fields.eeprom_data_out;
    assign m_frame_check        = out_fields.frame_check;

endmodule
